// ===== hdl/acfb_pkg.sv =====
// ----------------------------------------------------------------------------
// AES-128 CFB package
// Request types, the S-box table and the AES round and key schedule helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package acfb_pkg;

	localparam int CfgIndexWidth = 3;

	localparam logic [CfgIndexWidth-1:0] CFG_KEY_HIGH     = 3'd0;
	localparam logic [CfgIndexWidth-1:0] CFG_KEY_LOW      = 3'd1;
	localparam logic [CfgIndexWidth-1:0] CFG_IV_HIGH      = 3'd2;
	localparam logic [CfgIndexWidth-1:0] CFG_IV_LOW       = 3'd3;
	localparam logic [CfgIndexWidth-1:0] CFG_DECRYPT_MODE = 3'd4;

	typedef struct packed {
		logic        restart;
		logic [63:0] data_high;
		logic [63:0] data_low;
	} in_req_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} out_req_t;

	localparam logic [7:0] RCON [0:9] = '{
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
	};

	localparam logic [7:0] SBOX [0:255] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [127:0] next_round_key(input logic [127:0] k,
		input logic [7:0] rc);
		logic [31:0] temp;
		logic [31:0] w0;
		logic [31:0] w1;
		logic [31:0] w2;
		logic [31:0] w3;
		temp = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
		w0 = k[127:96] ^ temp;
		w1 = k[95:64] ^ w0;
		w2 = k[63:32] ^ w1;
		w3 = k[31:0] ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	function automatic logic [127:0] cipher_round(input logic [127:0] s,
		input logic [127:0] rk, input logic last);
		logic [7:0] t [0:15];
		logic [7:0] a0;
		logic [7:0] a1;
		logic [7:0] a2;
		logic [7:0] a3;
		logic [7:0] all_x;
		logic [127:0] res;
		for (int c = 0; c < 4; c++) begin
			for (int row = 0; row < 4; row++) begin
				t[c*4+row] = SBOX[s[127 - 8*(((c + row) % 4)*4 + row) -: 8]];
			end
		end
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[c*4];
				a1 = t[c*4+1];
				a2 = t[c*4+2];
				a3 = t[c*4+3];
				all_x = a0 ^ a1 ^ a2 ^ a3;
				t[c*4]   = a0 ^ all_x ^ xtime(a0 ^ a1);
				t[c*4+1] = a1 ^ all_x ^ xtime(a1 ^ a2);
				t[c*4+2] = a2 ^ all_x ^ xtime(a2 ^ a3);
				t[c*4+3] = a3 ^ all_x ^ xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) begin
			res[127 - 8*i -: 8] = t[i];
		end
		return res ^ rk;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/aes128_cfb_block_cipher_unit.sv =====
// ----------------------------------------------------------------------------
// AES-128 CFB-128 block cipher unit
// Encrypts or decrypts one 128-bit block per request in cipher feedback mode.
// ----------------------------------------------------------------------------
// Each request holds one 128-bit block as two 64-bit halves. The unit takes one
// request per clock cycle unless stalled by out_ready, and its result appears on
// the output register in the following cycle. All ten AES rounds and the key
// schedule are combinational between the chaining and result registers, so that
// path sets the clock rate. Set restart on the first block of a message to chain
// from the configured IV. Write the configuration only while the unit is idle.
`default_nettype none

module aes128_cfb_block_cipher_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire acfb_pkg::in_req_t                    in_data,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output acfb_pkg::out_req_t                        out_data,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [acfb_pkg::CfgIndexWidth-1:0]   cfg_index,
	input  wire logic [63:0]                          cfg_data
);

	logic [127:0] key_q;
	logic [127:0] iv_q;
	logic         decrypt_q;
	logic [127:0] chain_q;
	logic         out_valid_q;
	acfb_pkg::out_req_t out_data_q;

	logic [127:0] rk [0:10];
	logic [127:0] st [0:10];
	logic [127:0] chain_sel;
	logic [127:0] block_in;
	logic [127:0] block_out;
	logic         in_fire;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign block_in  = {in_data.data_high, in_data.data_low};
	assign chain_sel = in_data.restart ? iv_q : chain_q;

	always_comb begin
		rk[0] = key_q;
		for (int r = 1; r <= 10; r++) begin
			rk[r] = acfb_pkg::next_round_key(rk[r-1], acfb_pkg::RCON[r-1]);
		end
		st[0] = chain_sel ^ rk[0];
		for (int r = 1; r <= 10; r++) begin
			st[r] = acfb_pkg::cipher_round(st[r-1], rk[r], r == 10);
		end
	end

	assign block_out = block_in ^ st[10];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q     <= '0;
			iv_q      <= '0;
			decrypt_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				acfb_pkg::CFG_KEY_HIGH:     key_q[127:64] <= cfg_data;
				acfb_pkg::CFG_KEY_LOW:      key_q[63:0]   <= cfg_data;
				acfb_pkg::CFG_IV_HIGH:      iv_q[127:64]  <= cfg_data;
				acfb_pkg::CFG_IV_LOW:       iv_q[63:0]    <= cfg_data;
				acfb_pkg::CFG_DECRYPT_MODE: decrypt_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				chain_q <= decrypt_q ? block_in : block_out;
			end
			if (in_ready) begin
				out_valid_q <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_data_q.result_high <= block_out[127:64];
			out_data_q.result_low  <= block_out[63:0];
		end
	end

endmodule

`default_nettype wire

// ===== tb/tb_aes128_cfb_block_cipher_unit.sv =====
// ----------------------------------------------------------------------------
// AES-128 CFB-128 block cipher unit testbench
// Drives random and directed blocks through the unit under several keys, IVs
// and modes, and checks every result against a behavioral AES-128 CFB model.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_aes128_cfb_block_cipher_unit;

	typedef enum int {
		IDLE_NONE,
		IDLE_RANDOM
	} idle_mode_e;

	localparam logic [acfb_pkg::CfgIndexWidth-1:0] CFG_UNUSED_LOW  = 3'd5;
	localparam logic [acfb_pkg::CfgIndexWidth-1:0] CFG_UNUSED_HIGH = 3'd7;
	localparam int NumPhases = 52;

	// Keystream model and the queue of expected output blocks.
	class cfb_scoreboard;
		logic [127:0]       key;
		logic [127:0]       iv;
		logic               decrypt;
		logic [127:0]       chain;
		acfb_pkg::out_req_t pending[$];
		int                 errors;
		int                 checked;

		function logic [127:0] aes_encrypt(input logic [127:0] blk, input logic [127:0] k);
			logic [127:0] rk;
			logic [127:0] st;
			logic [7:0]   rc;
			logic [7:0]   b [0:15];
			logic [7:0]   t [0:15];
			logic [7:0]   a0;
			logic [7:0]   a1;
			logic [7:0]   a2;
			logic [7:0]   a3;
			logic [7:0]   sum;
			logic [31:0]  w;
			rk = k;
			st = blk ^ k;
			rc = 8'h01;
			for (int r = 1; r <= 10; r++) begin
				w = {acfb_pkg::SBOX[rk[23:16]] ^ rc, acfb_pkg::SBOX[rk[15:8]],
					acfb_pkg::SBOX[rk[7:0]], acfb_pkg::SBOX[rk[31:24]]};
				rk[127:96] = rk[127:96] ^ w;
				rk[95:64] = rk[95:64] ^ rk[127:96];
				rk[63:32] = rk[63:32] ^ rk[95:64];
				rk[31:0] = rk[31:0] ^ rk[63:32];
				rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
				for (int i = 0; i < 16; i++) begin
					b[i] = st[127 - 8*i -: 8];
				end
				for (int c = 0; c < 4; c++) begin
					for (int row = 0; row < 4; row++) begin
						t[c*4+row] = acfb_pkg::SBOX[b[((c + row) % 4)*4 + row]];
					end
				end
				if (r < 10) begin
					for (int c = 0; c < 4; c++) begin
						a0 = t[c*4];
						a1 = t[c*4+1];
						a2 = t[c*4+2];
						a3 = t[c*4+3];
						sum = a0 ^ a1 ^ a2 ^ a3;
						t[c*4]   = a0 ^ sum ^ gf_double(a0 ^ a1);
						t[c*4+1] = a1 ^ sum ^ gf_double(a1 ^ a2);
						t[c*4+2] = a2 ^ sum ^ gf_double(a2 ^ a3);
						t[c*4+3] = a3 ^ sum ^ gf_double(a3 ^ a0);
					end
				end
				for (int i = 0; i < 16; i++) begin
					st[127 - 8*i -: 8] = t[i];
				end
				st = st ^ rk;
			end
			return st;
		endfunction

		function logic [7:0] gf_double(input logic [7:0] x);
			return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
		endfunction

		function void reset_state();
			key = '0;
			iv = '0;
			decrypt = 1'b0;
			chain = '0;
			errors = 0;
			checked = 0;
		endfunction

		function void write_reg(input logic [acfb_pkg::CfgIndexWidth-1:0] idx,
			input logic [63:0] val);
			case (idx)
				acfb_pkg::CFG_KEY_HIGH: key[127:64] = val;
				acfb_pkg::CFG_KEY_LOW: key[63:0] = val;
				acfb_pkg::CFG_IV_HIGH: iv[127:64] = val;
				acfb_pkg::CFG_IV_LOW: iv[63:0] = val;
				acfb_pkg::CFG_DECRYPT_MODE: decrypt = val[0];
				default: ;
			endcase
		endfunction

		function void note_block(input acfb_pkg::in_req_t req);
			logic [127:0] blk;
			logic [127:0] res;
			blk = {req.data_high, req.data_low};
			if (req.restart) begin
				chain = iv;
			end
			res = blk ^ aes_encrypt(chain, key);
			chain = decrypt ? blk : res;
			pending.push_back(acfb_pkg::out_req_t'(res));
		endfunction

		task report(input string msg);
			errors++;
			$display("ERROR: %s", msg);
		endtask

		task check_block(input acfb_pkg::out_req_t got);
			acfb_pkg::out_req_t want;
			checked++;
			if (pending.size() == 0) begin
				report($sformatf("unexpected output block %h", got));
				return;
			end
			want = pending.pop_front();
			if (got.result_high !== want.result_high) begin
				report($sformatf("result_high %h, expected %h",
					got.result_high, want.result_high));
			end
			if (got.result_low !== want.result_low) begin
				report($sformatf("result_low %h, expected %h",
					got.result_low, want.result_low));
			end
		endtask
	endclass

	logic                                 clk;
	logic                                 arst_n;
	logic                                 in_valid;
	logic                                 in_ready;
	acfb_pkg::in_req_t                    in_data;
	logic                                 out_valid;
	logic                                 out_ready;
	acfb_pkg::out_req_t                   out_data;
	logic                                 cfg_valid;
	logic                                 cfg_ready;
	logic [acfb_pkg::CfgIndexWidth-1:0]   cfg_index;
	logic [63:0]                          cfg_data;

	cfb_scoreboard sb;
	idle_mode_e    send_idle;
	idle_mode_e    recv_idle;
	int            hold_off_cycles;
	int            cycle_count;
	int            blocks_sent;
	int            cfg_writes;
	bit            stimulus_done;

	aes128_cfb_block_cipher_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic write_reg(input logic [acfb_pkg::CfgIndexWidth-1:0] idx,
		input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		sb.write_reg(idx, val);
		cfg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [127:0] k, input logic [127:0] v, input logic mode);
		write_reg(acfb_pkg::CFG_KEY_HIGH, k[127:64]);
		write_reg(acfb_pkg::CFG_KEY_LOW, k[63:0]);
		write_reg(acfb_pkg::CFG_IV_HIGH, v[127:64]);
		write_reg(acfb_pkg::CFG_IV_LOW, v[63:0]);
		write_reg(acfb_pkg::CFG_DECRYPT_MODE, {$urandom(), 31'd0, mode});
	endtask

	task automatic send_block(input logic rst, input logic [63:0] hi, input logic [63:0] lo);
		acfb_pkg::in_req_t req;
		int gap;
		gap = (send_idle == IDLE_RANDOM) ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) begin
				@(posedge clk);
			end
		end
		req.restart = rst;
		req.data_high = hi;
		req.data_low = lo;
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		sb.note_block(req);
		blocks_sent++;
	endtask

	task automatic drain();
		if (in_valid) begin
			in_valid <= 1'b0;
		end
		while (sb.pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) begin
			@(posedge clk);
		end
	endtask

	// Receiver: accepts results, with random stalls or one long hold-off.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_block(out_data);
		end
	end

	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (hold_off_cycles) begin
					@(posedge clk);
				end
				hold_off_cycles = 0;
			end
			stall = (recv_idle == IDLE_RANDOM) ? $urandom_range(0, 16) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) begin
					@(posedge clk);
				end
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) begin
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		logic [127:0] k;
		logic [127:0] v;
		logic [127:0] plain [$];
		int len;
		sb = new();
		sb.reset_state();
		cycle_count = 0;
		blocks_sent = 0;
		cfg_writes = 0;
		hold_off_cycles = 0;
		stimulus_done = 0;
		send_idle = IDLE_NONE;
		recv_idle = IDLE_NONE;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (12) begin
			@(posedge clk);
		end
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: chaining from zero with no restart, then extremes of the fields.
		send_block(1'b0, 64'd0, 64'd0);
		send_block(1'b0, '1, '1);
		drain();
		configure(128'h2b7e151628aed2a6abf7158809cf4f3c,
			128'h000102030405060708090a0b0c0d0e0f, 1'b0);
		send_block(1'b1, 64'h6bc1bee22e409f96, 64'he93d7e117393172a);
		send_block(1'b0, 64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51);
		send_block(1'b1, '1, '1);
		send_block(1'b0, 64'd0, 64'd0);
		send_block(1'b0, 64'h8000000000000000, 64'h0000000000000001);
		drain();
		// Mode and key change mid-message keep the chaining value.
		write_reg(acfb_pkg::CFG_DECRYPT_MODE, 64'd1);
		send_block(1'b0, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
		drain();
		write_reg(acfb_pkg::CFG_KEY_LOW, '1);
		write_reg(CFG_UNUSED_LOW, rand64());
		write_reg(CFG_UNUSED_HIGH, rand64());
		send_block(1'b0, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
		send_block(1'b1, 64'd1, 64'd2);
		drain();
		configure('1, '1, 1'b0);
		send_block(1'b1, '1, 64'd0);
		send_block(1'b0, 64'd0, '1);
		drain();
		configure('0, '0, 1'b1);
		send_block(1'b1, 64'd0, 64'd0);
		send_block(1'b0, '1, '1);
		drain();

		// Long hold-off so the unit backs up and stalls its input.
		hold_off_cycles = 200;
		repeat (1) @(posedge clk);
		for (int i = 0; i < 20; i++) begin
			send_block(i == 0, rand64(), rand64());
		end
		drain();

		// Random phases: encrypt messages, then decrypt random blocks.
		send_idle = IDLE_RANDOM;
		recv_idle = IDLE_RANDOM;
		for (int phase = 0; phase < NumPhases; phase++) begin
			k = {rand64(), rand64()};
			v = {rand64(), rand64()};
			if (phase % 4 == 0) begin
				send_idle = IDLE_NONE;
				recv_idle = IDLE_NONE;
			end else begin
				send_idle = IDLE_RANDOM;
				recv_idle = IDLE_RANDOM;
			end
			configure(k, v, 1'b0);
			plain.delete();
			for (int m = 0; m < 4; m++) begin
				len = $urandom_range(1, 9);
				for (int j = 0; j < len; j++) begin
					plain.push_back({rand64(), rand64()});
					send_block((j == 0) || ($urandom_range(0, 31) == 0),
						plain[$][127:64], plain[$][63:0]);
				end
			end
			drain();
			write_reg(acfb_pkg::CFG_DECRYPT_MODE, 64'd1);
			for (int j = 0; j < 10; j++) begin
				send_block($urandom_range(0, 7) == 0, rand64(), rand64());
			end
			drain();
		end
		send_idle = IDLE_NONE;
		recv_idle = IDLE_NONE;
		drain();

		$display("Covered %0d blocks and %0d register writes over %0d key/IV/mode settings,",
			blocks_sent, cfg_writes, NumPhases);
		$display("including restarts, mid-message changes and a long output stall.");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
